@@ rtl/fir_pkg.sv @@
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types, constants and the power-up coefficient table of the Q15 FIR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fir_pkg;

    localparam int MAX_TAPS_DEFAULT = 63;
    localparam int SAMPLE_W         = 16;
    localparam int TAP_W            = 6;
    localparam int ADDR_W           = 6;
    localparam int IDX_W            = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int OUT_SHIFT        = 15;
    localparam int BANDPASS_LEN     = 63;
    localparam int BANDPASS_AW      = $clog2(BANDPASS_LEN);

    localparam logic [TAP_W-1:0] TAPS_RESET = 6'd63;

    // func codes
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam longint ROUND_TERM = 64'sd16384;
    localparam longint Q30_MAX    = 64'sh3fffffff;
    localparam longint Q30_MIN    = -64'sh40000000;

    localparam logic signed [SAMPLE_W-1:0] BANDPASS [BANDPASS_LEN] = '{
        -16'sd179,   16'sd319,  -16'sd176,    16'sd50,   16'sd506,   16'sd543,
          16'sd25,  -16'sd383,  -16'sd217,    16'sd11,  -16'sd253,  -16'sd466,
          16'sd86,   16'sd815,   16'sd632,   -16'sd98,  -16'sd145,   16'sd273,
        -16'sd225, -16'sd1371, -16'sd1190,   16'sd531,  16'sd1388,   16'sd440,
         16'sd153,  16'sd1826,  16'sd2036, -16'sd2161, -16'sd6608, -16'sd4213,
        16'sd4160,  16'sd8922,  16'sd4160, -16'sd4213, -16'sd6608, -16'sd2161,
        16'sd2036,  16'sd1826,   16'sd153,   16'sd440,  16'sd1388,   16'sd531,
       -16'sd1190, -16'sd1371,  -16'sd225,   16'sd273,  -16'sd145,   -16'sd98,
         16'sd632,   16'sd815,    16'sd86,  -16'sd466,  -16'sd253,    16'sd11,
        -16'sd217,  -16'sd383,    16'sd25,   16'sd543,   16'sd506,    16'sd50,
        -16'sd176,   16'sd319,  -16'sd179
    };

    // one classified item as it sits in the queue
    typedef struct packed {
        logic                       kind;
        logic [IDX_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] data;
    } fir_op_t;

    typedef struct packed {
        logic    valid;
        fir_op_t op;
    } fir_qbeat_t;

    function automatic int fir_aw(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // coefficient seen before the entry is first written
    function automatic logic signed [SAMPLE_W-1:0] fir_coef_init(input logic [IDX_W-1:0] idx);
        logic signed [SAMPLE_W-1:0] val;
        val = '0;
        if (idx < IDX_W'(BANDPASS_LEN))
        begin
            val = BANDPASS[idx[BANDPASS_AW-1:0]];
        end
        return val;
    endfunction

endpackage

@@ rtl/fir_if.sv @@
// ----------------------------------------------------------------------------
// fir_if
// Valid/ready channels of the Q15 FIR: input items, results, tap count writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fir_item_if import fir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]          coef_addr;
    logic signed [SAMPLE_W-1:0] coef_value;

    modport source (output valid, func, sample, coef_addr, coef_value, input ready);
    modport sink (input valid, func, sample, coef_addr, coef_value, output ready);
endinterface

interface fir_result_if import fir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink (input valid, filtered, output ready);
endinterface

interface fir_cfg_if import fir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAP_W-1:0] tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink (input valid, tap_count, output ready);
endinterface

@@ rtl/fir_ram.sv @@
// ----------------------------------------------------------------------------
// fir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_ram import fir_pkg::*; #(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = MAX_TAPS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [fir_aw(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [fir_aw(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fir_front.sv @@
// ----------------------------------------------------------------------------
// fir_front
// Takes input beats and tap count writes, classifies items for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_front import fir_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    fir_item_if.sink                     item,
    fir_cfg_if.sink                      cfg,
    input  logic                         q_full,
    output fir_qbeat_t                   push,
    output logic [fir_aw(MAX_TAPS)-1:0]  last_tap
);

    localparam int AW = fir_aw(MAX_TAPS);
    localparam int CW = ($clog2(MAX_TAPS + 1) > TAP_W) ? $clog2(MAX_TAPS + 1) : TAP_W;

    logic [TAP_W-1:0] tap_count_reg;
    logic [CW-1:0]    taps_raw;
    logic [CW-1:0]    taps_eff;
    logic             addr_ok;
    logic             beat;

    assign cfg.ready  = 1'b1;
    assign item.ready = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAPS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            tap_count_reg <= cfg.tap_count;
        end
    end

    // clamp tap count into 1 .. MAX_TAPS
    always_comb
    begin
        taps_raw = CW'(tap_count_reg);
        if (taps_raw == '0)
        begin
            taps_eff = CW'(1);
        end
        else if (taps_raw > CW'(MAX_TAPS))
        begin
            taps_eff = CW'(MAX_TAPS);
        end
        else
        begin
            taps_eff = taps_raw;
        end
        last_tap = AW'(taps_eff - CW'(1));
    end

    // out-of-range coefficient writes are taken and dropped
    always_comb
    begin
        beat          = item.valid && item.ready;
        addr_ok       = CW'(item.coef_addr) < CW'(MAX_TAPS);
        push.op.kind  = item.func;
        push.op.addr  = IDX_W'(item.coef_addr);
        push.op.data  = (item.func == FUNC_COEF) ? item.coef_value : item.sample;
        push.valid    = beat && ((item.func == FUNC_FILTER) || addr_ok);
    end

endmodule

@@ rtl/fir_queue.sv @@
// ----------------------------------------------------------------------------
// fir_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_queue import fir_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  fir_qbeat_t push,
    output logic       full,
    input  logic       pop,
    output fir_qbeat_t head
);

    localparam int PW  = fir_aw(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    fir_op_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [CNW-1:0] count_reg;
    logic [CNW-1:0] count_next;

    assign full       = (count_reg == CNW'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = slot_reg[rp_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wp_reg] <= push.op;
        end
    end

endmodule

@@ rtl/fir_back.sv @@
// ----------------------------------------------------------------------------
// fir_back
// Executes queued items: coefficient writes, and filter items on one shared MAC, one tap at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_back import fir_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fir_qbeat_t                   head,
    output logic                         pop,
    input  logic [fir_aw(MAX_TAPS)-1:0]  last_tap,
    fir_result_if.source                 result
);

    localparam int AW       = fir_aw(MAX_TAPS);
    localparam int DL_DEPTH = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int DL_AW    = fir_aw(DL_DEPTH);
    localparam int FW       = $clog2(DL_DEPTH + 1);
    localparam int CMPW     = (AW > FW) ? AW : FW;
    localparam int ACC_W    = 33 + $clog2(MAX_TAPS);

    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(Q30_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(Q30_MIN);
    localparam logic signed [ACC_W-1:0] ACC_INIT = ACC_W'(ROUND_TERM);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SAT   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [AW-1:0]              k_reg;
    logic [AW-1:0]              last_reg;
    logic [DL_AW-1:0]           rp_reg;
    logic [DL_AW-1:0]           head_reg;
    logic [DL_AW-1:0]           head_inc;
    logic [FW-1:0]              fill_reg;
    logic [MAX_TAPS-1:0]        cvalid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;

    logic                       s1_valid_reg;
    logic                       s1_first_reg;
    logic                       s1_live_reg;
    logic                       s1_cvalid_reg;
    logic signed [SAMPLE_W-1:0] s1_init_reg;
    logic                       s2_valid_reg;
    logic signed [31:0]         s2_prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic                       start_coef;
    logic                       start_filter;
    logic                       issue;
    logic                       out_free;
    logic                       finish;
    logic signed [SAMPLE_W-1:0] coef_op;
    logic signed [SAMPLE_W-1:0] samp_op;
    logic signed [30:0]         sat_val;

    logic                       coef_we;
    logic [AW-1:0]              coef_waddr;
    logic [SAMPLE_W-1:0]        coef_rdata;
    logic                       dl_we;
    logic [SAMPLE_W-1:0]        dl_rdata;

    assign result.valid    = out_valid_reg;
    assign result.filtered = out_data_reg;

    always_comb
    begin
        out_free     = !out_valid_reg || result.ready;
        pop          = (state_reg == ST_IDLE) && head.valid;
        start_coef   = pop && (head.op.kind == FUNC_COEF);
        start_filter = pop && (head.op.kind == FUNC_FILTER);
        issue        = (state_reg == ST_MAC);
        finish       = (state_reg == ST_OUT) && out_free;
        coef_we      = start_coef;
        coef_waddr   = AW'(head.op.addr);
        dl_we        = finish;
        head_inc     = (head_reg == DL_AW'(DL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_filter)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (k_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operand select: tap 0 takes the new sample, history past the fill count is zero
    always_comb
    begin
        coef_op = s1_cvalid_reg ? $signed(coef_rdata) : s1_init_reg;
        if (s1_first_reg)
        begin
            samp_op = x_reg;
        end
        else if (s1_live_reg)
        begin
            samp_op = $signed(dl_rdata);
        end
        else
        begin
            samp_op = '0;
        end
    end

    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sat_val = 31'(SAT_HI);
        end
        else if (acc_reg < SAT_LO)
        begin
            sat_val = 31'(SAT_LO);
        end
        else
        begin
            sat_val = 31'(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            rp_reg        <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            cvalid_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (start_coef)
            begin
                cvalid_reg[coef_waddr] <= 1'b1;
            end
            if (start_filter)
            begin
                k_reg  <= '0;
                rp_reg <= head_reg;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg != '0)
                begin
                    rp_reg <= (rp_reg == '0) ? DL_AW'(DL_DEPTH - 1) : rp_reg - 1'b1;
                end
            end
            if (finish)
            begin
                head_reg      <= head_inc;
                fill_reg      <= (fill_reg == FW'(DL_DEPTH)) ? fill_reg : fill_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_filter)
        begin
            x_reg    <= head.op.data;
            last_reg <= last_tap;
            acc_reg  <= ACC_INIT;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(s2_prod_reg);
        end
        if (issue)
        begin
            s1_first_reg  <= (k_reg == '0);
            s1_live_reg   <= (k_reg != '0) && (CMPW'(k_reg) <= CMPW'(fill_reg));
            s1_cvalid_reg <= cvalid_reg[k_reg];
            s1_init_reg   <= fir_coef_init(IDX_W'(k_reg));
        end
        if (s1_valid_reg)
        begin
            s2_prod_reg <= coef_op * samp_op;
        end
        if (state_reg == ST_SAT)
        begin
            res_reg <= sat_val[OUT_SHIFT +: SAMPLE_W];
        end
        if (finish)
        begin
            out_data_reg <= res_reg;
        end
    end

    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (head.op.data),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    // delay line as a ring: newest past sample sits at head_reg
    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DL_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (head_inc),
        .wdata (x_reg),
        .raddr (rp_reg),
        .rdata (dl_rdata)
    );

endmodule

@@ rtl/fir_q15_filter_unit.sv @@
// ----------------------------------------------------------------------------
// fir_q15_filter_unit: Q15 direct-form FIR, sample in, filtered sample out
// Items go one at a time through the single shared multiply-accumulate unit,
// one tap per cycle; the next is popped once the last result is registered.
// A coefficient write is done when popped. Reset empties the delay line at
// once and coefficients read as the bandpass set until written; no clear pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_q15_filter_unit import fir_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    fir_item_if.sink     item,
    fir_cfg_if.sink      cfg,
    fir_result_if.source result
);

    localparam int AW = fir_aw(MAX_TAPS);

    fir_qbeat_t    push;
    fir_qbeat_t    q_head;
    logic          q_full;
    logic          q_pop;
    logic [AW-1:0] last_tap;

    fir_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .last_tap (last_tap)
    );

    fir_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    fir_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .last_tap (last_tap),
        .result   (result)
    );

endmodule

@@ rtl/fir_checker.sv @@
// ----------------------------------------------------------------------------
// fir_checker
// Port-level assertions on the Q15 FIR, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_checker import fir_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       item_func,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic signed [SAMPLE_W-1:0] result_filtered
);

    // queue slots, one item in the back end, one in the output register
    localparam int MAX_PENDING = QUEUE_DEPTH + 2;
    localparam int PCW         = $clog2(MAX_PENDING + 1) + 1;

    logic [PCW-1:0] pending_reg;
    logic           in_filter;
    logic           out_beat;

    assign in_filter = item_valid && item_ready && (item_func == FUNC_FILTER);
    assign out_beat  = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + PCW'(in_filter) - PCW'(out_beat);
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_filtered))
        else $error("result payload changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pending_reg != '0)
        else $error("result beat without a pending filter item");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PCW'(MAX_PENDING))
        else $error("more filter items in flight than the pipeline holds");

endmodule

bind fir_q15_filter_unit fir_checker u_fir_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_func       (item.func),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_filtered (result.filtered)
);
